// ----- design/lls_pkg.sv -----
// shared constants, types and hash functions of the loglog sketch update block
`default_nettype none
package lls_pkg;

   localparam int MAX_REGISTERS_DEF = 16384;

   localparam int ACT_W   = 15;
   localparam int BYTE_W  = 8;
   localparam int IDX_W   = 14;
   localparam int VAL_W   = 6;
   localparam int HASH_W  = 32;

   localparam logic [ACT_W-1:0]  ACTIVE_RESET = 15'd2000;
   localparam logic [HASH_W-1:0] HASH_SEED    = 32'd5381;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [HASH_W-1:0] MIX_C1 = 32'h7ed55d16;
   localparam logic [HASH_W-1:0] MIX_C2 = 32'hc761c23c;
   localparam logic [HASH_W-1:0] MIX_C3 = 32'h165667b1;
   localparam logic [HASH_W-1:0] MIX_C4 = 32'hd3a2646c;
   localparam logic [HASH_W-1:0] MIX_C5 = 32'hfd7046c5;
   localparam logic [HASH_W-1:0] MIX_C6 = 32'hb55a4f09;

   typedef struct packed {
      logic byte_en;
      logic restart;
   } hash_ctl_type;

   // first three rounds of the integer mix
   function automatic logic [HASH_W-1:0] mix_a(input logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] t;
      t = v + MIX_C1 + (v << 12);
      t = t ^ MIX_C2 ^ (t >> 19);
      t = t + MIX_C3 + (t << 5);
      return t;
   endfunction

   // last three rounds of the integer mix
   function automatic logic [HASH_W-1:0] mix_b(input logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] t;
      t = (v + MIX_C4) ^ (v << 9);
      t = t + MIX_C5 + (t << 3);
      t = t ^ MIX_C6 ^ (t >> 16);
      return t;
   endfunction

   // all ones gives 32
   function automatic logic [VAL_W-1:0] trailing_ones(input logic [HASH_W-1:0] v);
      logic [VAL_W-1:0] n;
      n = VAL_W'(HASH_W);
      for (int i = HASH_W - 1; i >= 0; i--) begin
         if (!v[i]) begin
            n = VAL_W'(i);
         end
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ----- design/lls_store.sv -----
// sketch register memory, one write and one registered read per cycle
`default_nettype none
module lls_store #(
   parameter int MAX_REGISTERS = lls_pkg::MAX_REGISTERS_DEF,
   localparam int AW = $clog2(MAX_REGISTERS)
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [AW-1:0]            rd_addr,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire logic [lls_pkg::VAL_W-1:0] wr_data,
   output      logic [lls_pkg::VAL_W-1:0] rd_data
);

   logic [lls_pkg::VAL_W-1:0] mem [MAX_REGISTERS];
   logic [lls_pkg::VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/lls_hash.sv -----
// djb2 byte accumulator with zero-byte termination
`default_nettype none
module lls_hash (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lls_pkg::hash_ctl_type         ctl,
   input  wire logic [lls_pkg::BYTE_W-1:0]    key_byte,
   output      logic [lls_pkg::HASH_W-1:0]    hash
);

   logic [lls_pkg::HASH_W-1:0] hash_ff, hash_in;
   logic                       ended_ff, ended_in;

   always_comb begin
      hash_in  = hash_ff;
      ended_in = ended_ff;
      if (ctl.restart) begin
         hash_in  = lls_pkg::HASH_SEED;
         ended_in = 1'b0;
      end else if (ctl.byte_en && !ended_ff) begin
         if (key_byte == '0) begin
            ended_in = 1'b1;
         end else begin
            // hash * 33 + byte
            hash_in = hash_ff + (hash_ff << 5)
                    + lls_pkg::HASH_W'(key_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= lls_pkg::HASH_SEED;
         ended_ff <= 1'b0;
      end else begin
         hash_ff  <= hash_in;
         ended_ff <= ended_in;
      end
   end

   assign hash = hash_ff;

endmodule
`default_nettype wire

// ----- design/lls_seq.sv -----
// sequencer: clear sweep, per-key register walk with read-modify-write, reads
`default_nettype none
module lls_seq #(
   parameter int MAX_REGISTERS = lls_pkg::MAX_REGISTERS_DEF,
   localparam int AW = $clog2(MAX_REGISTERS),
   localparam int CW = $clog2(MAX_REGISTERS + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          operation,
   input  wire logic                          last_byte,
   input  wire logic [lls_pkg::IDX_W-1:0]     read_index,
   input  wire logic [lls_pkg::ACT_W-1:0]     active_count,
   input  wire logic [lls_pkg::HASH_W-1:0]    hash,
   output      lls_pkg::hash_ctl_type         hash_ctl,
   output      logic                          busy,
   output      logic                          rsp_strobe,
   output      logic [lls_pkg::VAL_W-1:0]     rsp_value,
   output      logic                          mem_rd_en,
   output      logic [AW-1:0]                 mem_rd_addr,
   output      logic                          mem_wr_en,
   output      logic [AW-1:0]                 mem_wr_addr,
   output      logic [lls_pkg::VAL_W-1:0]     mem_wr_data,
   input  wire logic [lls_pkg::VAL_W-1:0]     mem_rd_data
);

   localparam int LW = (CW > lls_pkg::ACT_W) ? CW : lls_pkg::ACT_W;
   localparam int XW = (CW > lls_pkg::IDX_W) ? CW : lls_pkg::IDX_W;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CLEAR = 7'b0000010,
      S_PRE_A = 7'b0000100,
      S_PRE_B = 7'b0001000,
      S_UPD_A = 7'b0010000,
      S_UPD_B = 7'b0100000,
      S_READ  = 7'b1000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic [lls_pkg::HASH_W-1:0] v_ff, v_in;
   logic [lls_pkg::VAL_W-1:0]  k_ff, k_in;
   logic                       oor_ff, oor_in;

   logic                       accept;
   logic [LW-1:0]              act_ext;
   logic [CW-1:0]              limit;
   logic [XW-1:0]              ri_ext;
   logic [CW-1:0]              idx_next;
   logic [lls_pkg::VAL_W-1:0]  max_val;

   assign accept   = start && (state_ff == S_IDLE);
   assign act_ext  = LW'(active_count);
   assign limit    = (act_ext > LW'(MAX_REGISTERS)) ? CW'(MAX_REGISTERS)
                                                    : CW'(act_ext);
   assign ri_ext   = XW'(read_index);
   assign idx_next = idx_ff + CW'(1);
   assign max_val  = (k_ff > mem_rd_data) ? k_ff : mem_rd_data;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      v_in     = v_ff;
      k_in     = k_ff;
      oor_in   = oor_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (operation == lls_pkg::OP_READ) begin
                  oor_in   = (ri_ext >= XW'(MAX_REGISTERS));
                  state_in = S_READ;
               end else if (last_byte) begin
                  state_in = S_PRE_A;
               end
            end
         end
         S_CLEAR: begin
            if (idx_ff == CW'(MAX_REGISTERS - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_next;
            end
         end
         S_PRE_A: begin
            v_in     = lls_pkg::mix_a(hash);
            state_in = S_PRE_B;
         end
         S_PRE_B: begin
            v_in   = lls_pkg::mix_b(v_ff);
            idx_in = '0;
            if (limit == '0) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_UPD_A;
            end
         end
         S_UPD_A: begin
            // count taken before the value is re-mixed
            k_in     = lls_pkg::trailing_ones(v_ff);
            v_in     = lls_pkg::mix_a(v_ff);
            state_in = S_UPD_B;
         end
         S_UPD_B: begin
            v_in = lls_pkg::mix_b(v_ff);
            if (idx_next == limit) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_next;
               state_in = S_UPD_A;
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      k_ff   <= k_in;
      oor_ff <= oor_in;
   end

   // one entry is read and written back per register, never overlapping
   assign mem_rd_en   = (accept && (operation == lls_pkg::OP_READ))
                     || (state_ff == S_UPD_A);
   assign mem_rd_addr = (state_ff == S_IDLE) ? ri_ext[AW-1:0] : idx_ff[AW-1:0];
   assign mem_wr_en   = (state_ff == S_CLEAR) || (state_ff == S_UPD_B);
   assign mem_wr_addr = idx_ff[AW-1:0];
   assign mem_wr_data = (state_ff == S_CLEAR) ? '0 : max_val;

   assign hash_ctl.byte_en = accept && (operation == lls_pkg::OP_KEY);
   assign hash_ctl.restart = (state_ff == S_PRE_A);

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_READ);
   assign rsp_value  = oor_ff ? '0 : mem_rd_data;

endmodule
`default_nettype wire

// ----- design/loglog_sketch_update.sv -----
// top level of the loglog sketch update block
//
//   channel   ports                           transfer
//   request   start, busy, req_*              start high while busy low
//   response  rsp_strobe, rsp_register_value  one cycle per strobe
//   csr       csr_wr_en, csr_wr_data          any edge with csr_wr_en high
//
// key byte that is not last: busy stays low; read: result in the cycle after it is taken
// last key byte: mix in S_PRE_A and S_PRE_B, then a walk over N registers,
//   N = active_count capped at MAX_REGISTERS; each register passes S_UPD_A and
//   S_UPD_B of the serial mix chain and one read-modify-write of the store
// after reset busy stays high while the store is zeroed
// results cannot be held off by the receiver
`default_nettype none
module loglog_sketch_update #(
   parameter int MAX_REGISTERS = lls_pkg::MAX_REGISTERS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic                          req_operation,
   input  wire logic [lls_pkg::BYTE_W-1:0]    req_key_byte,
   input  wire logic                          req_last_byte,
   input  wire logic [lls_pkg::IDX_W-1:0]     req_read_index,
   output      logic                          rsp_strobe,
   output      logic [lls_pkg::VAL_W-1:0]     rsp_register_value,
   input  wire logic                          csr_wr_en,
   input  wire logic [lls_pkg::ACT_W-1:0]     csr_wr_data
);

   localparam int AW = $clog2(MAX_REGISTERS);

   logic [lls_pkg::ACT_W-1:0]  active_count_ff, active_count_in;
   lls_pkg::hash_ctl_type      hash_ctl;
   logic [lls_pkg::HASH_W-1:0] hash;
   logic                       mem_rd_en;
   logic [AW-1:0]              mem_rd_addr;
   logic                       mem_wr_en;
   logic [AW-1:0]              mem_wr_addr;
   logic [lls_pkg::VAL_W-1:0]  mem_wr_data;
   logic [lls_pkg::VAL_W-1:0]  mem_rd_data;

   assign active_count_in = csr_wr_en ? csr_wr_data : active_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff <= lls_pkg::ACTIVE_RESET;
      end else begin
         active_count_ff <= active_count_in;
      end
   end

   lls_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .ctl      (hash_ctl),
      .key_byte (req_key_byte),
      .hash     (hash)
   );

   lls_seq #(
      .MAX_REGISTERS (MAX_REGISTERS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .operation    (req_operation),
      .last_byte    (req_last_byte),
      .read_index   (req_read_index),
      .active_count (active_count_ff),
      .hash         (hash),
      .hash_ctl     (hash_ctl),
      .busy         (busy),
      .rsp_strobe   (rsp_strobe),
      .rsp_value    (rsp_register_value),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_data  (mem_rd_data)
   );

   lls_store #(
      .MAX_REGISTERS (MAX_REGISTERS)
   ) u_store (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

endmodule
`default_nettype wire

// ----- design/lls_checker.sv -----
// port-level checks for the loglog sketch update block, bound to the top level
`default_nettype none
module lls_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      start,
   input wire logic                      busy,
   input wire logic                      req_operation,
   input wire logic                      req_last_byte,
   input wire logic                      rsp_strobe,
   input wire logic [lls_pkg::VAL_W-1:0] rsp_register_value
);

   logic read_xfer;
   logic key_xfer;

   assign read_xfer = start && !busy && (req_operation == lls_pkg::OP_READ);
   assign key_xfer  = start && !busy && (req_operation == lls_pkg::OP_KEY);

   a_read_gives_result: assert property (@(posedge clock) disable iff (reset)
      read_xfer |=> rsp_strobe)
      else $error("read transfer without result");

   a_result_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(read_xfer))
      else $error("result without read transfer");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_register_value <= lls_pkg::VAL_W'(32)))
      else $error("register value above 32");

   a_last_byte_busy: assert property (@(posedge clock) disable iff (reset)
      (key_xfer && req_last_byte) |=> busy)
      else $error("no update walk after last byte");

   a_plain_byte_free: assert property (@(posedge clock) disable iff (reset)
      (key_xfer && !req_last_byte) |=> !busy)
      else $error("busy after plain key byte");

endmodule

bind loglog_sketch_update lls_checker u_lls_checker (.*);
`default_nettype wire

// ----- bench/loglog_sketch_check.sv -----
// checker for the loglog sketch update block: predicts register reads and compares them
`timescale 1ns / 100ps
module loglog_sketch_check #(
   parameter int SKETCH_DEPTH = lls_pkg::MAX_REGISTERS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic                       req_operation,
   input  logic [lls_pkg::BYTE_W-1:0] req_key_byte,
   input  logic                       req_last_byte,
   input  logic [lls_pkg::IDX_W-1:0]  req_read_index,
   input  logic                       rsp_strobe,
   input  logic [lls_pkg::VAL_W-1:0]  rsp_register_value,
   input  logic                       csr_wr_en,
   input  logic [lls_pkg::ACT_W-1:0]  csr_wr_data,
   output int                         fail_count,
   output int                         pending
);

   logic [lls_pkg::VAL_W-1:0]  sketch_regs [SKETCH_DEPTH];
   logic [lls_pkg::HASH_W-1:0] key_hash;
   logic                       key_closed;
   logic [lls_pkg::ACT_W-1:0]  active_regs;
   logic [lls_pkg::VAL_W-1:0]  reads_due [$];
   int                         mismatch_total;

   initial begin
      fail_count = 0;
      pending = 0;
      mismatch_total = 0;
   end

   function automatic logic [31:0] scramble_word(input logic [31:0] v);
      logic [31:0] w;
      w = v + lls_pkg::MIX_C1 + (v << 12);
      w = w ^ lls_pkg::MIX_C2 ^ (w >> 19);
      w = w + lls_pkg::MIX_C3 + (w << 5);
      w = (w + lls_pkg::MIX_C4) ^ (w << 9);
      w = w + lls_pkg::MIX_C5 + (w << 3);
      w = w ^ lls_pkg::MIX_C6 ^ (w >> 16);
      return w;
   endfunction

   function automatic logic [lls_pkg::VAL_W-1:0] low_ones_run(input logic [31:0] v);
      int n;
      n = 0;
      while (n < 32 && v[n]) n++;
      return lls_pkg::VAL_W'(n);
   endfunction

   // walk the active registers, keeping the longest run seen per register
   task automatic fold_key_into_sketch(input logic [31:0] seed_word);
      logic [31:0]               w;
      logic [lls_pkg::VAL_W-1:0] run;
      int                        limit;
      w = seed_word;
      limit = (int'(active_regs) > SKETCH_DEPTH) ? SKETCH_DEPTH : int'(active_regs);
      for (int i = 0; i < limit; i++) begin
         run = low_ones_run(w);
         if (run > sketch_regs[i]) sketch_regs[i] = run;
         w = scramble_word(w);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SKETCH_DEPTH; i++) sketch_regs[i] = '0;
         key_hash = lls_pkg::HASH_SEED;
         key_closed = 1'b0;
         active_regs = lls_pkg::ACTIVE_RESET;
         reads_due.delete();
      end else begin
         if (csr_wr_en) active_regs = csr_wr_data;
         if (start && !busy) begin
            if (req_operation == lls_pkg::OP_READ) begin
               reads_due.push_back(sketch_regs[req_read_index]);
            end else begin
               // a zero byte closes the key; later bytes leave the hash alone
               if (!key_closed) begin
                  if (req_key_byte == 8'h00) key_closed = 1'b1;
                  else key_hash = key_hash * 33 + req_key_byte;
               end
               if (req_last_byte) begin
                  fold_key_into_sketch(scramble_word(key_hash));
                  key_hash = lls_pkg::HASH_SEED;
                  key_closed = 1'b0;
               end
            end
         end
         if (rsp_strobe) begin
            if (reads_due.size() == 0) begin
               $display("%0t: register read with none outstanding, expected nothing, got %0d",
                        $time, rsp_register_value);
               mismatch_total++;
            end else begin
               if (rsp_register_value !== reads_due[0]) begin
                  $display("%0t: register_value mismatch, expected %0d, got %0d",
                           $time, reads_due[0], rsp_register_value);
                  mismatch_total++;
               end
               void'(reads_due.pop_front());
            end
         end
      end
      fail_count <= mismatch_total + reads_due.size();
      pending <= reads_due.size();
   end

endmodule

// ----- bench/loglog_sketch_update_tb.sv -----
// testbench top for the loglog sketch update block: stimulus, run limit and verdict
`timescale 1ns / 100ps
module loglog_sketch_update_tb;

   localparam int SKETCH_DEPTH = lls_pkg::MAX_REGISTERS_DEF;
   localparam int CYCLE_LIMIT  = 6000000;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_operation = lls_pkg::OP_KEY;
   logic [lls_pkg::BYTE_W-1:0] req_key_byte = '0;
   logic                       req_last_byte = 1'b0;
   logic [lls_pkg::IDX_W-1:0]  req_read_index = '0;
   logic                       rsp_strobe;
   logic [lls_pkg::VAL_W-1:0]  rsp_register_value;
   logic                       csr_wr_en = 1'b0;
   logic [lls_pkg::ACT_W-1:0]  csr_wr_data = '0;
   int                         fail_count;
   int                         pending;

   int cycle_count = 0;
   int live_regs = int'(lls_pkg::ACTIVE_RESET);
   int key_bytes_sent = 0;
   int reads_sent = 0;
   int settings_used = 0;
   bit steady = 1'b0;

   loglog_sketch_update #(.MAX_REGISTERS(SKETCH_DEPTH)) u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_key_byte       (req_key_byte),
      .req_last_byte      (req_last_byte),
      .req_read_index     (req_read_index),
      .rsp_strobe         (rsp_strobe),
      .rsp_register_value (rsp_register_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   loglog_sketch_check #(.SKETCH_DEPTH(SKETCH_DEPTH)) u_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_key_byte       (req_key_byte),
      .req_last_byte      (req_last_byte),
      .req_read_index     (req_read_index),
      .rsp_strobe         (rsp_strobe),
      .rsp_register_value (rsp_register_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // start stays high from one transfer to the next unless the sender idles
   task automatic send_item(input logic op, input logic [7:0] kb, input logic lb,
                            input logic [13:0] ri);
      while (!steady && $urandom_range(99) < 25) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_key_byte <= kb;
      req_last_byte <= lb;
      req_read_index <= ri;
      do @(posedge clock); while (busy);
      if (op == lls_pkg::OP_READ) reads_sent++;
      else key_bytes_sent++;
   endtask

   // drain all reads, then give a trailing key update time to finish its walk
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2 * live_regs + 16) @(posedge clock);
   endtask

   task automatic write_active(input logic [14:0] value);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      live_regs = (int'(value) > SKETCH_DEPTH) ? SKETCH_DEPTH : int'(value);
      settings_used++;
   endtask

   task automatic random_traffic(input int n_items);
      int          sent;
      int          len;
      int          span;
      logic [13:0] ri;
      logic [7:0]  kb;
      sent = 0;
      span = (live_regs + 3 > 16383) ? 16383 : live_regs + 3;
      while (sent < n_items) begin
         if ($urandom_range(99) < 30) begin
            ri = ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(span));
            send_item(lls_pkg::OP_READ, 8'($urandom), 1'($urandom), ri);
            sent++;
         end else begin
            len = $urandom_range(1, 6);
            for (int b = 0; b < len; b++) begin
               // reads slipped into the middle of a key must not disturb its hash
               if ($urandom_range(9) == 0) begin
                  send_item(lls_pkg::OP_READ, 8'($urandom), 1'($urandom),
                            14'($urandom_range(span)));
                  sent++;
               end
               kb = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom);
               send_item(lls_pkg::OP_KEY, kb, b == len - 1, 14'($urandom));
            end
            sent += len;
         end
         if ($urandom_range(24) == 0) settle();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // store clearing pass after reset
      @(posedge clock);
      while (busy) @(posedge clock);

      // directed part at the reset active count
      send_item(lls_pkg::OP_READ, 8'hff, 1'b1, 14'd0);
      send_item(lls_pkg::OP_READ, 8'h00, 1'b0, 14'h3fff);
      send_item(lls_pkg::OP_KEY, 8'hff, 1'b0, 14'h3fff);
      send_item(lls_pkg::OP_KEY, 8'h01, 1'b1, 14'd0);
      send_item(lls_pkg::OP_READ, 8'h00, 1'b0, 14'd0);
      send_item(lls_pkg::OP_READ, 8'h5a, 1'b1, 14'd1999);
      send_item(lls_pkg::OP_READ, 8'h00, 1'b0, 14'd2000);
      send_item(lls_pkg::OP_KEY, 8'h41, 1'b0, 14'd0);
      send_item(lls_pkg::OP_KEY, 8'h00, 1'b0, 14'd0);
      send_item(lls_pkg::OP_KEY, 8'h7f, 1'b0, 14'd0);
      send_item(lls_pkg::OP_KEY, 8'h80, 1'b1, 14'd0);
      send_item(lls_pkg::OP_KEY, 8'h00, 1'b1, 14'd0);
      send_item(lls_pkg::OP_KEY, 8'hff, 1'b1, 14'd0);
      send_item(lls_pkg::OP_READ, 8'hff, 1'b0, 14'd1);
      send_item(lls_pkg::OP_READ, 8'h00, 1'b1, 14'h2aaa);
      send_item(lls_pkg::OP_READ, 8'h00, 1'b0, 14'h1555);
      send_item(lls_pkg::OP_KEY, 8'h00, 1'b0, 14'd0);
      send_item(lls_pkg::OP_KEY, 8'h00, 1'b1, 14'd0);
      send_item(lls_pkg::OP_READ, 8'h00, 1'b0, 14'd0);
      send_item(lls_pkg::OP_READ, 8'h00, 1'b0, 14'd2);

      write_active(15'd10);
      random_traffic(50);
      write_active(15'd0);
      random_traffic(25);
      write_active(15'd1);
      random_traffic(25);
      write_active(15'd16384);
      random_traffic(12);
      // above the store size, saturates
      write_active(15'h7fff);
      random_traffic(8);
      for (int p = 0; p < 6; p++) begin
         write_active(15'($urandom_range(10, 200)));
         steady = (p == 3);
         random_traffic(30);
      end
      steady = 1'b0;
      settle();

      $display("run covered %0d key bytes and %0d register reads", key_bytes_sent, reads_sent);
      $display("over %0d active-count settings, from 0 up to a saturating 32767",
               settings_used + 1);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
